FILE: rtl/cdh_pkg.sv
// shared types and constants of the calibrated dithered histogrammer
package cdh_pkg;

   // operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // event class codes
   localparam logic [1:0] CLASS_NONE     = 2'd0;
   localparam logic [1:0] CLASS_COUNTED  = 2'd1;
   localparam logic [1:0] CLASS_OVERFLOW = 2'd2;
   localparam logic [1:0] CLASS_READ     = 2'd3;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN   = 8'd1;

   localparam int unsigned OFFSET_W = 32;
   localparam int unsigned GAIN_W   = 24;
   localparam int unsigned ENERGY_W = 16;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned BIN_W    = 14;
   localparam int unsigned OUT_W    = 32;
   localparam int unsigned PROD_W   = GAIN_W + ENERGY_W + 1;
   localparam int unsigned CAL_W    = PROD_W + 1;
   localparam int unsigned CHAN_W   = CAL_W - FRAC_W + 1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

   typedef struct packed {
      logic                operation;
      logic [ENERGY_W-1:0] raw_energy;
      logic [FRAC_W-1:0]   dither;
      logic [BIN_W-1:0]    read_bin;
   } req_type;

   typedef struct packed {
      logic [1:0]       event_class;
      logic [BIN_W-1:0] channel;
      logic [OUT_W-1:0] bin_count;
      logic [OUT_W-1:0] valid_total;
      logic [OUT_W-1:0] overflow_total;
   } rsp_type;

endpackage

FILE: rtl/calibrated_dithered_histogrammer_core.sv
// calibrated dithered pulse-height histogrammer, top level
//
// Usage:
//  - req channel: drive req_data and raise start; the word is taken at a rising edge
//    where start is high and busy is low. operation record calibrates raw_energy
//    with offset + gain * energy (Q16), dithers the rounding and counts a nonzero
//    bin, or the overflow past the last bin; operation read returns one bin.
//  - rsp channel: exactly one result word per request, shown on rsp_data for a
//    single cycle with rsp_valid high. The receiver cannot stall; it must take it.
//  - csr channel: csr_ready is always high; index 0 writes the offset, index 1
//    the gain, other indexes are dropped. Write only while the block is idle.
//  - sequence: an accepted word passes the multiply stage, the calibration add,
//    the histogram read through its registered read port and the write-back
//    stage, one word at a time. The result is shown in the cycle in which busy
//    falls; no new word is taken before then.
//  - reset: synchronous, active high. Afterwards the histogram memory is cleared
//    one bin per cycle with busy high; the counters, offset and gain reset.
module calibrated_dithered_histogrammer_core #(
   parameter int unsigned BINS        = 16384,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  cdh_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   output cdh_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cdh_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [cdh_pkg::OFFSET_W-1:0]           csr_data
);

   localparam int unsigned ADDR_W = $clog2(BINS);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_CAL   = 6'b001000,
      ST_READ  = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] hist_mem [BINS];

   logic signed [cdh_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic signed [cdh_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   cdh_pkg::req_type                    req_ff, req_in;
   logic signed [cdh_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [1:0]                          class_ff, class_in;
   logic [ADDR_W-1:0]                   addr_ff, addr_in;
   logic [cdh_pkg::BIN_W-1:0]           chan_ff, chan_in;
   logic                                in_range_ff, in_range_in;
   logic [ADDR_W-1:0]                   clr_ff, clr_in;
   logic [COUNT_WIDTH-1:0]              valid_ff, valid_in;
   logic [COUNT_WIDTH-1:0]              ovf_ff, ovf_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   cdh_pkg::rsp_type                    rsp_ff, rsp_in;
   logic [COUNT_WIDTH-1:0]              rd_ff;

   logic                                accept;
   logic signed [cdh_pkg::CAL_W-1:0]    cal;
   logic [cdh_pkg::CHAN_W-1:0]          chan_full;
   logic                                dither_up;
   logic [COUNT_WIDTH-1:0]              bin_next;
   logic                                wr_en;
   logic [ADDR_W-1:0]                   wr_addr;
   logic [COUNT_WIDTH-1:0]              wr_data;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // calibration arithmetic, exact in Q16
   assign cal       = cdh_pkg::CAL_W'(offset_ff) + cdh_pkg::CAL_W'(prod_ff);
   assign dither_up = req_ff.dither < cal[cdh_pkg::FRAC_W-1:0];
   assign chan_full = cdh_pkg::CHAN_W'(cal[cdh_pkg::CAL_W-1:cdh_pkg::FRAC_W])
                      + cdh_pkg::CHAN_W'(dither_up);

   assign bin_next = (rd_ff == '1) ? rd_ff : rd_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      gain_in      = gain_ff;
      req_in       = req_ff;
      prod_in      = prod_ff;
      class_in     = class_ff;
      addr_in      = addr_ff;
      chan_in      = chan_ff;
      in_range_in  = in_range_ff;
      clr_in       = clr_ff;
      valid_in     = valid_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = bin_next;

      if (csr_valid && csr_ready) begin
         if (csr_index == cdh_pkg::REG_OFFSET) begin
            offset_in = csr_data;
         end else if (csr_index == cdh_pkg::REG_GAIN) begin
            gain_in = csr_data[cdh_pkg::GAIN_W-1:0];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = cdh_pkg::PROD_W'(gain_ff)
                       * cdh_pkg::PROD_W'($signed({1'b0, req_ff.raw_energy}));
            state_in = ST_CAL;
         end
         ST_CAL: begin
            class_in    = cdh_pkg::CLASS_NONE;
            chan_in     = '0;
            in_range_in = 1'b0;
            addr_in     = chan_full[ADDR_W-1:0];
            if (req_ff.operation == cdh_pkg::OP_READ) begin
               class_in    = cdh_pkg::CLASS_READ;
               chan_in     = req_ff.read_bin;
               in_range_in = 32'(req_ff.read_bin) < 32'(BINS);
               addr_in     = ADDR_W'(req_ff.read_bin);
            end else if (req_ff.raw_energy != '0 && !cal[cdh_pkg::CAL_W-1]
                         && chan_full != '0) begin
               if (32'(chan_full) < 32'(BINS)) begin
                  class_in    = cdh_pkg::CLASS_COUNTED;
                  chan_in     = chan_full[cdh_pkg::BIN_W-1:0];
                  in_range_in = 1'b1;
               end else begin
                  class_in = cdh_pkg::CLASS_OVERFLOW;
               end
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            rsp_in.event_class = class_ff;
            rsp_in.channel     = chan_ff;
            rsp_in.bin_count   = '0;
            if (class_ff == cdh_pkg::CLASS_COUNTED) begin
               wr_en    = 1'b1;
               valid_in = (valid_ff == '1) ? valid_ff : valid_ff + 1'b1;
               rsp_in.bin_count = cdh_pkg::OUT_W'(bin_next);
            end else if (class_ff == cdh_pkg::CLASS_OVERFLOW) begin
               ovf_in = (ovf_ff == '1) ? ovf_ff : ovf_ff + 1'b1;
            end else if (class_ff == cdh_pkg::CLASS_READ && in_range_ff) begin
               rsp_in.bin_count = cdh_pkg::OUT_W'(rd_ff);
            end
            rsp_in.valid_total    = cdh_pkg::OUT_W'(valid_in);
            rsp_in.overflow_total = cdh_pkg::OUT_W'(ovf_in);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         offset_ff    <= '0;
         gain_ff      <= cdh_pkg::GAIN_RESET;
         clr_ff       <= '0;
         valid_ff     <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         gain_ff      <= gain_in;
         clr_ff       <= clr_in;
         valid_ff     <= valid_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      prod_ff     <= prod_in;
      class_ff    <= class_in;
      addr_ff     <= addr_in;
      chan_ff     <= chan_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

   // histogram memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_ff <= hist_mem[addr_ff];
   end

   // every accepted word answers after the fixed pipeline latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("missing response after accepted word");

   // a result is only shown when the block is ready for the next word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // bin zero is never incremented
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_WRITE) |-> (wr_addr != '0))
      else $error("increment of bin zero");

   // a response marks the end of an update: no overflow and valid count together
   assert property (@(posedge clock) disable iff (reset)
      !(valid_ff != $past(valid_ff) && ovf_ff != $past(ovf_ff)))
      else $error("valid and overflow counts moved together");

endmodule
